/* src/audio_downmix_history_buffer_unit_defines.svh */
// assertion macros shared by the history buffer rtl
// each macro expects clk and rst to be visible where it is used
`ifndef AUDIO_DOWNMIX_HISTORY_BUFFER_UNIT_DEFINES_SVH
`define AUDIO_DOWNMIX_HISTORY_BUFFER_UNIT_DEFINES_SVH

// antecedent holds, consequent checked in the same cycle
`define ADHB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("implication check failed");

// antecedent holds, consequent checked in the next cycle
`define ADHB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("next cycle check failed");

// condition holds at every clock edge out of reset
`define ADHB_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`endif

/* src/adhb_pkg.sv */
`default_nettype none

package adhb_pkg;

  // sample and accumulator widths
  localparam int SAMPLE_W     = 16;
  localparam int MAX_CHANNELS = 8;
  localparam int SUM_W        = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int QUOT_W       = SAMPLE_W + 1;

  // reciprocal multiply for division by channel count
  localparam int RECIP_SHIFT = SUM_W + 3;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam int DEFAULT_HISTORY_DEPTH = 16384;

  // field widths of the channels
  localparam int REQ_W     = 16;
  localparam int IDX_W     = 14;
  localparam int WIN_LEN_W = 15;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 8;

  localparam logic [3:0] MAX_CH_CODE = 4'(MAX_CHANNELS);

  // operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // format codes
  localparam logic [1:0] FMT_FLOAT = 2'd0;
  localparam logic [1:0] FMT_PCM   = 2'd1;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MODE   = CFG_IDX_W'(1);
  localparam logic [3:0]           CHANNEL_COUNT_RST = 4'd2;
  localparam logic [1:0]           FORMAT_MODE_RST   = FMT_FLOAT;

  typedef struct packed {
    logic [1:0]                 op;
    logic                       silent;
    logic signed [SAMPLE_W-1:0] chan0;
    logic signed [SAMPLE_W-1:0] chan1;
    logic signed [SAMPLE_W-1:0] chan2;
    logic signed [SAMPLE_W-1:0] chan3;
    logic signed [SAMPLE_W-1:0] chan4;
    logic signed [SAMPLE_W-1:0] chan5;
    logic signed [SAMPLE_W-1:0] chan6;
    logic signed [SAMPLE_W-1:0] chan7;
    logic [REQ_W-1:0]           window_request;
    logic [IDX_W-1:0]           window_index;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [WIN_LEN_W-1:0]       window_length;
    logic                       index_valid;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_req_t;

  // control from the sequencer to the history store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } hist_ctrl_t;

  // ceil(2^RECIP_SHIFT / d), exact floor quotient for any sum magnitude
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      4'd1:    r = RECIP_W'(4194304);
      4'd2:    r = RECIP_W'(2097152);
      4'd3:    r = RECIP_W'(1398102);
      4'd4:    r = RECIP_W'(1048576);
      4'd5:    r = RECIP_W'(838861);
      4'd6:    r = RECIP_W'(699051);
      4'd7:    r = RECIP_W'(599187);
      4'd8:    r = RECIP_W'(524288);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/adhb_stream_if.sv */
`default_nettype none

interface adhb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/adhb_downmix.sv */
`default_nettype none

module adhb_downmix (
  input  wire logic                                  clk,
  input  wire logic                                  load,
  input  wire adhb_pkg::item_t                       frame,
  input  wire logic [3:0]                            channel_count,
  input  wire logic [1:0]                            format_mode,
  output logic signed [adhb_pkg::SAMPLE_W-1:0]       mono
);

  localparam int SW   = adhb_pkg::SUM_W;
  localparam int RW   = adhb_pkg::RECIP_W;
  localparam int QW   = adhb_pkg::QUOT_W;
  localparam int PW   = SW + RW;

  logic signed [adhb_pkg::SAMPLE_W-1:0] chans [adhb_pkg::MAX_CHANNELS];
  logic [3:0]           ch_eff;
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        mag;
  logic                 zero_c;

  logic [SW-1:0]        mag_r;
  logic                 neg_r;
  logic                 zero_r;
  logic [3:0]           ch_r;
  logic [PW-1:0]        prod;
  logic [QW-1:0]        quot;

  assign chans[0] = frame.chan0;
  assign chans[1] = frame.chan1;
  assign chans[2] = frame.chan2;
  assign chans[3] = frame.chan3;
  assign chans[4] = frame.chan4;
  assign chans[5] = frame.chan5;
  assign chans[6] = frame.chan6;
  assign chans[7] = frame.chan7;

  // clamp the channel count into the supported range
  always_comb begin
    priority if (channel_count == 4'd0) begin
      ch_eff = 4'd1;
    end else if (channel_count > adhb_pkg::MAX_CH_CODE) begin
      ch_eff = adhb_pkg::MAX_CH_CODE;
    end else begin
      ch_eff = channel_count;
    end
  end

  // signed sum of the active channels, split into sign and magnitude
  always_comb begin
    sum = '0;
    for (int c = 0; c < adhb_pkg::MAX_CHANNELS; c++) begin
      if (c < int'(ch_eff)) begin
        sum = sum + SW'(chans[c]);
      end
    end
    mag    = sum[SW-1] ? SW'(-sum) : SW'(sum);
    zero_c = frame.silent || (format_mode > adhb_pkg::FMT_PCM);
  end

  // first stage: sum captured with the request
  always_ff @(posedge clk) begin
    if (load) begin
      mag_r  <= mag;
      neg_r  <= sum[SW-1];
      zero_r <= zero_c;
      ch_r   <= ch_eff;
    end
  end

  // second stage: magnitude times reciprocal, quotient truncates toward zero
  assign prod = PW'(mag_r) * PW'(adhb_pkg::recip(ch_r));

  always_ff @(posedge clk) begin
    quot <= prod[adhb_pkg::RECIP_SHIFT +: QW];
  end

  // restore sign, forced to zero for silent or unsupported frames
  always_comb begin
    priority if (zero_r) begin
      mono = '0;
    end else if (neg_r) begin
      mono = adhb_pkg::SAMPLE_W'(-quot);
    end else begin
      mono = adhb_pkg::SAMPLE_W'(quot);
    end
  end

endmodule

`default_nettype wire

/* src/adhb_history.sv */
`default_nettype none
`include "audio_downmix_history_buffer_unit_defines.svh"

module adhb_history #(
  parameter int HISTORY_DEPTH = adhb_pkg::DEFAULT_HISTORY_DEPTH,
  localparam int AW = $clog2(HISTORY_DEPTH),
  localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire adhb_pkg::hist_ctrl_t            ctrl,
  input  wire logic [adhb_pkg::SAMPLE_W-1:0]   wr_data,
  input  wire logic [adhb_pkg::REQ_W-1:0]      win_request,
  input  wire logic [adhb_pkg::IDX_W-1:0]      win_index,
  output logic [adhb_pkg::SAMPLE_W-1:0]        rd_data,
  output logic [CW-1:0]                        win_len,
  output logic                                 idx_ok
);

  localparam int XW = ((CW > adhb_pkg::REQ_W) ? CW : adhb_pkg::REQ_W) + 1;
  localparam int SW = XW + 1;

  logic [adhb_pkg::SAMPLE_W-1:0] mem [HISTORY_DEPTH];

  logic [AW-1:0]        wp;
  logic [AW-1:0]        wp_next;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        fill_next;
  logic [CW-1:0]        n;
  logic                 idx_ok_c;
  logic signed [SW-1:0] s0;
  logic signed [SW-1:0] s1;
  logic [AW-1:0]        rd_addr;

  // write position and fill count, clear wins over a write in the same cycle
  always_comb begin
    wp_next   = (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + AW'(1);
    fill_next = (fill < CW'(HISTORY_DEPTH)) ? fill + CW'(1) : fill;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (ctrl.clear) begin
      wp   <= '0;
      fill <= '0;
    end else if (ctrl.wr_en) begin
      wp   <= wp_next;
      fill <= fill_next;
    end
  end

  // window clamp and oldest-first address, wrapped once around the store
  always_comb begin
    n        = (XW'(win_request) < XW'(fill)) ? CW'(win_request) : fill;
    idx_ok_c = XW'(win_index) < XW'(n);
    s0       = SW'(wp) + SW'(win_index) - SW'(n);
    s1       = SW'(wp) + SW'(win_index) + SW'(HISTORY_DEPTH) - SW'(n);
    rd_addr  = s0[SW-1] ? AW'(s1) : AW'(s0);
  end

  // store write port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wp] <= wr_data;
    end
  end

  // store read port with registered window status
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
      win_len <= n;
      idx_ok  <= idx_ok_c;
    end
  end

  `ADHB_ASSERT_IMPL(a_wp_tracks_fill, fill < CW'(HISTORY_DEPTH), wp == AW'(fill))
  `ADHB_ASSERT_NEXT(a_clear_empties, ctrl.clear, fill == '0)
  `ADHB_ASSERT_ALWAYS(a_no_rw_overlap, !(ctrl.wr_en && ctrl.rd_en))

endmodule

`default_nettype wire

/* src/audio_downmix_history_buffer_unit.sv */
// push: frame stored in the history after the sum and quotient registers, a new request taken at the store
// read: store read registered, then result register loaded; a new request is taken as that result is loaded,
//   so requests wait while the result output is stalled
// clear: takes effect at acceptance, next request can follow in the next cycle
// reset: control state cleared, channel_count 2, format_mode 0; the history store
//   keeps its contents and is reached only through entries written since reset or clear
`default_nettype none
`include "audio_downmix_history_buffer_unit_defines.svh"

module audio_downmix_history_buffer_unit #(
  parameter int HISTORY_DEPTH = adhb_pkg::DEFAULT_HISTORY_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  adhb_stream_if.sink   item,
  adhb_stream_if.source result,
  adhb_stream_if.sink   cfg
);

  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_WRITE = 5'b00100,
    S_RADDR = 5'b01000,
    S_RDATA = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  state_t dispatch;

  logic [3:0] channel_count;
  logic [1:0] format_mode;

  logic accept;
  logic out_free;
  logic out_load;
  logic out_valid;

  logic [adhb_pkg::REQ_W-1:0] req_r;
  logic [adhb_pkg::IDX_W-1:0] idx_r;

  adhb_pkg::hist_ctrl_t hctrl;

  logic signed [adhb_pkg::SAMPLE_W-1:0] mono;
  logic [adhb_pkg::SAMPLE_W-1:0]        rd_data;
  logic [CW-1:0]                        win_len;
  logic                                 idx_ok;

  // configuration registers, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= adhb_pkg::CHANNEL_COUNT_RST;
      format_mode   <= adhb_pkg::FORMAT_MODE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        adhb_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg.payload.data[3:0];
        adhb_pkg::CFG_FORMAT_MODE:   format_mode   <= cfg.payload.data[1:0];
        default: ;
      endcase
    end
  end

  // request handshake: taken when idle, at the store cycle, or as a read result leaves
  assign out_free   = !out_valid || result.ready;
  assign item.ready = (state == S_IDLE) || (state == S_WRITE) ||
                      ((state == S_RDATA) && out_free);
  assign accept     = item.valid && item.ready;

  // first state of a newly accepted request
  always_comb begin
    priority if (accept && (item.payload.op == adhb_pkg::OP_PUSH)) begin
      dispatch = S_MUL;
    end else if (accept && (item.payload.op == adhb_pkg::OP_READ)) begin
      dispatch = S_RADDR;
    end else begin
      dispatch = S_IDLE;
    end
  end

  // sequencer
  always_comb begin
    unique case (state)
      S_IDLE:  state_next = dispatch;
      S_MUL:   state_next = S_WRITE;
      S_WRITE: state_next = dispatch;
      S_RADDR: state_next = S_RDATA;
      S_RDATA: state_next = out_free ? dispatch : S_RDATA;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read window fields held for the address cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= item.payload.window_request;
      idx_r <= item.payload.window_index;
    end
  end

  // history store control
  always_comb begin
    hctrl.wr_en = (state == S_WRITE);
    hctrl.rd_en = (state == S_RADDR);
    hctrl.clear = accept && (item.payload.op == adhb_pkg::OP_CLEAR);
  end

  adhb_downmix u_downmix (
    .clk           (clk),
    .load          (accept && (item.payload.op == adhb_pkg::OP_PUSH)),
    .frame         (item.payload),
    .channel_count (channel_count),
    .format_mode   (format_mode),
    .mono          (mono)
  );

  adhb_history #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (hctrl),
    .wr_data     (adhb_pkg::SAMPLE_W'(mono)),
    .win_request (req_r),
    .win_index   (idx_r),
    .rd_data     (rd_data),
    .win_len     (win_len),
    .idx_ok      (idx_ok)
  );

  // result register
  assign out_load = (state == S_RDATA) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.payload.sample_out    <= idx_ok ? rd_data : '0;
      result.payload.window_length <= adhb_pkg::WIN_LEN_W'(win_len);
      result.payload.index_valid   <= idx_ok;
    end
  end

  assign result.valid = out_valid;

  `ADHB_ASSERT_IMPL(a_push_writes, accept && (item.payload.op == adhb_pkg::OP_PUSH), ##2 hctrl.wr_en)
  `ADHB_ASSERT_NEXT(a_read_lands, hctrl.rd_en, state == S_RDATA)
  `ADHB_ASSERT_IMPL(a_result_from_read, $rose(out_valid), $past(state == S_RDATA))

endmodule

`default_nettype wire

/* tb/sv/audio_downmix_history_buffer_unit_tb.sv */
module audio_downmix_history_buffer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adhb_pkg::*;

  localparam int HIST_DEPTH    = DEFAULT_HISTORY_DEPTH;
  localparam int SEG_COUNT     = 10;
  localparam int SEG_ITEMS     = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 12;
  localparam int QUIET_LIMIT   = 5000;

  // codes that the package leaves unnamed
  localparam logic [1:0]           OP_NONE    = 2'd3;
  localparam logic [1:0]           FMT_ZERO   = 2'd2;
  localparam logic [1:0]           FMT_ZERO_B = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = CFG_IDX_W'(15);

  typedef struct {
    item_t   req;
    bit      fixed;
    result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  adhb_stream_if #(.payload_t(item_t))    item_ch ();
  adhb_stream_if #(.payload_t(result_t))  result_ch ();
  adhb_stream_if #(.payload_t(cfg_req_t)) cfg_ch ();

  audio_downmix_history_buffer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // mirror of the block state
  logic [15:0] hist_mem [HIST_DEPTH];
  int          wr_ptr;
  int          fill_cnt;
  logic [3:0]  ch_cnt_reg;
  logic [1:0]  fmt_reg;

  result_t pending_reads [$];
  dir_row_t dir_rows [$];
  int errors;
  int send_gap_pct;
  int recv_stall_pct;
  bit hold_request;
  int quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // downmix, store and window lookup for one request
  function automatic bit step_history(input item_t req, output result_t res);
    logic signed [15:0] chs [8];
    int nch;
    int sum;
    int n;
    int idx;
    chs = '{req.chan0, req.chan1, req.chan2, req.chan3,
            req.chan4, req.chan5, req.chan6, req.chan7};
    res = '0;
    case (req.op)
      OP_PUSH: begin
        sum = 0;
        if (!req.silent && fmt_reg <= FMT_PCM) begin
          nch = (ch_cnt_reg == 0) ? 1 : (ch_cnt_reg > MAX_CHANNELS) ? MAX_CHANNELS
                                                                    : int'(ch_cnt_reg);
          for (int c = 0; c < nch; c++) sum += int'(chs[c]);
          sum = sum / nch;
        end
        hist_mem[wr_ptr] = sum[15:0];
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (fill_cnt < HIST_DEPTH) fill_cnt++;
        return 1'b0;
      end
      OP_READ: begin
        n   = (int'(req.window_request) < fill_cnt) ? int'(req.window_request) : fill_cnt;
        idx = int'(req.window_index);
        res.window_length = WIN_LEN_W'(n);
        if (idx < n) begin
          res.sample_out  = hist_mem[(wr_ptr + HIST_DEPTH - n + idx) % HIST_DEPTH];
          res.index_valid = 1'b1;
        end
        return 1'b1;
      end
      OP_CLEAR: begin
        wr_ptr   = 0;
        fill_cnt = 0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [15:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly pushes and reads aimed at the filled part of the history
  function automatic item_t rand_item();
    item_t it;
    int pick;
    int win;
    it.chan0 = rand_sample();
    it.chan1 = rand_sample();
    it.chan2 = rand_sample();
    it.chan3 = rand_sample();
    it.chan4 = rand_sample();
    it.chan5 = rand_sample();
    it.chan6 = rand_sample();
    it.chan7 = rand_sample();
    it.silent = ($urandom_range(0, 9) == 0);
    it.window_request = 16'($urandom);
    it.window_index   = 14'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      it.op = OP_PUSH;
    end else if (pick < 94) begin
      it.op = OP_READ;
      pick = $urandom_range(0, 9);
      if (pick < 5) it.window_request = 16'($urandom_range(0, fill_cnt + 2));
      else if (pick < 7) it.window_request = 16'hFFFF;
      else if (pick == 7) it.window_request = 16'(HIST_DEPTH);
      win = (int'(it.window_request) < fill_cnt) ? int'(it.window_request) : fill_cnt;
      // index mostly inside the window, sometimes just past its end
      if ($urandom_range(0, 3) != 0) it.window_index = 14'($urandom_range(0, win));
    end else if (pick < 97) begin
      it.op = OP_CLEAR;
    end else begin
      it.op = OP_NONE;
    end
    return it;
  endfunction

  function automatic item_t frame(input logic [15:0] c0, input logic [15:0] c1,
                                  input bit sil = 1'b0);
    item_t it;
    it = '{op: OP_PUSH, silent: sil, chan0: c0, chan1: c1,
           chan2: 16'h8000, chan3: 16'h7FFF, chan4: 16'h8000, chan5: 16'h7FFF,
           chan6: 16'h8000, chan7: 16'h7FFF, window_request: 16'hFFFF,
           window_index: 14'h3FFF};
    return it;
  endfunction

  function automatic item_t window_read(input logic [15:0] req, input logic [13:0] idx);
    item_t it;
    it = '0;
    it.op = OP_READ;
    it.window_request = req;
    it.window_index = idx;
    return it;
  endfunction

  function automatic item_t bare(input logic [1:0] op);
    item_t it;
    it = rand_item();
    it.op = op;
    return it;
  endfunction

  function automatic dir_row_t row(input item_t req, input bit fixed = 1'b0,
                                   input logic [15:0] s = '0, input int len = 0,
                                   input bit v = 1'b0);
    dir_row_t r;
    r.req = req;
    r.fixed = fixed;
    r.want = '{sample_out: s, window_length: WIN_LEN_W'(len), index_valid: v};
    return r;
  endfunction

  // offer one request and predict once it is taken
  task automatic send_request(input item_t req, input bit fixed = 1'b0,
                              input result_t want = '0);
    result_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.payload <= req;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (step_history(req, predicted)) pending_reads.push_back(fixed ? want : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_CHANNEL_COUNT) ch_cnt_reg = val[3:0];
    else if (idx == CFG_FORMAT_MODE) fmt_reg = val[1:0];
  endtask

  task automatic set_config(input logic [7:0] cc, input logic [7:0] fm, input bit spare = 1'b0);
    write_reg(CFG_CHANNEL_COUNT, cc);
    write_reg(CFG_FORMAT_MODE, fm);
    if (spare) write_reg(CFG_SPARE, 8'hFF);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every read result, then let pushes and clears settle
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_reads.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %0d %0d %0d", $time,
               got.sample_out, got.window_length, got.index_valid);
      errors++;
    end else begin
      want = pending_reads.pop_front();
      if (got.sample_out !== want.sample_out)
        note_mismatch("sample_out", want.sample_out, got.sample_out);
      if (got.window_length !== want.window_length)
        note_mismatch("window_length", want.window_length, got.window_length);
      if (got.index_valid !== want.index_valid)
        note_mismatch("index_valid", want.index_valid, got.index_valid);
    end
  endtask

  // result side: check, random stalls and the long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) check_result(result_ch.payload);
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("audio_downmix_history_buffer_unit test failed");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    logic [7:0] cc_list [SEG_COUNT];
    logic [7:0] fm_list [SEG_COUNT];
    cc_list = '{8'h01, 8'h08, 8'h00, 8'hF3, 8'h0F, 8'h05, 8'h07, 8'h19, 8'h06, 8'h04};
    fm_list = '{{6'h00, FMT_PCM}, {6'h00, FMT_FLOAT}, {6'h3F, FMT_PCM}, {6'h00, FMT_ZERO},
                {6'h15, FMT_FLOAT}, {6'h2A, FMT_ZERO_B}, {6'h00, FMT_PCM},
                {6'h3F, FMT_FLOAT}, {6'h00, FMT_PCM}, {6'h00, FMT_FLOAT}};
    errors = 0;
    hold_request = 1'b0;
    wr_ptr = 0;
    fill_cnt = 0;
    ch_cnt_reg = CHANNEL_COUNT_RST;
    fmt_reg = FORMAT_MODE_RST;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    send_gap_pct = 30;
    recv_stall_pct = 71;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty history, extremes, rounding toward zero, silent, ignored code, clear
    dir_rows.push_back(row(window_read(16'h0000, 14'h0000), 1'b1, 16'h0000, 0, 1'b0));
    dir_rows.push_back(row(window_read(16'hFFFF, 14'h3FFF), 1'b1, 16'h0000, 0, 1'b0));
    dir_rows.push_back(row(frame(16'h7FFF, 16'h7FFF)));
    dir_rows.push_back(row(frame(16'h8000, 16'h8000)));
    dir_rows.push_back(row(frame(16'h8000, 16'h7FFF)));
    dir_rows.push_back(row(frame(16'hFFFD, 16'h0000)));
    dir_rows.push_back(row(frame(16'h7FFF, 16'h7FFF, 1'b1)));
    dir_rows.push_back(row(bare(OP_NONE)));
    dir_rows.push_back(row(window_read(16'hFFFF, 14'h0000), 1'b1, 16'h7FFF, 5, 1'b1));
    dir_rows.push_back(row(window_read(16'h0005, 14'h0004), 1'b1, 16'h0000, 5, 1'b1));
    dir_rows.push_back(row(window_read(16'h0003, 14'h0001), 1'b1, 16'hFFFF, 3, 1'b1));
    dir_rows.push_back(row(window_read(16'h0002, 14'h0002), 1'b1, 16'h0000, 2, 1'b0));
    dir_rows.push_back(row(window_read(16'hFFFF, 14'h3FFF), 1'b1, 16'h0000, 5, 1'b0));
    dir_rows.push_back(row(window_read(16'h0001, 14'h0000), 1'b1, 16'h0000, 1, 1'b1));
    dir_rows.push_back(row(window_read(16'h0005, 14'h0001), 1'b1, 16'h8000, 5, 1'b1));
    dir_rows.push_back(row(bare(OP_CLEAR)));
    dir_rows.push_back(row(window_read(16'hFFFF, 14'h0000), 1'b1, 16'h0000, 0, 1'b0));
    dir_rows.push_back(row(frame(16'h5555, 16'hAAAA)));
    dir_rows.push_back(row(frame(16'hAAAA, 16'h5555)));
    dir_rows.push_back(row(frame(16'h0001, 16'h0000)));
    dir_rows.push_back(row(window_read(16'h0003, 14'h0000)));
    dir_rows.push_back(row(window_read(16'h0003, 14'h0001)));
    dir_rows.push_back(row(window_read(16'h0003, 14'h0002)));
    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
    drain();

    // random segments, one register setting each
    for (int s = 0; s < SEG_COUNT; s++) begin
      if (s < 4) begin
        send_gap_pct = 30;
        recv_stall_pct = 71;
      end else if (s < 7) begin
        send_gap_pct = 71;
        recv_stall_pct = 30;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      set_config(cc_list[s], fm_list[s], s == 3);
      repeat (SEG_ITEMS) send_request(rand_item());
      drain();
    end

    // long result hold-off while reads keep coming
    hold_request = 1'b1;
    repeat (150) send_request(bare(OP_READ));
    drain();

    // pushes over all eight channels, then reads across and past the window
    set_config(8'h08, {6'h00, FMT_PCM});
    repeat (60) send_request(bare(OP_PUSH));
    send_request(window_read(16'hFFFF, 14'h0000));
    send_request(window_read(16'hFFFF, 14'h3FFF));
    send_request(window_read(16'(HIST_DEPTH), 14'h3FFF));
    send_request(window_read(16'(HIST_DEPTH + 1), 14'h2000));
    repeat (10) send_request(bare(OP_READ));
    drain();

    if (errors == 0) begin
      $display("audio_downmix_history_buffer_unit test passed");
    end else begin
      $display("audio_downmix_history_buffer_unit test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/adhb_pkg.sv
src/adhb_stream_if.sv
src/adhb_downmix.sv
src/adhb_history.sv
src/audio_downmix_history_buffer_unit.sv
tb/sv/audio_downmix_history_buffer_unit_tb.sv
